// ----- hw/rtl/rpc_pkg.sv -----
// ---------------------------------------------------------------------------
// rpc_pkg
// Shared widths and request types for the rolling correlation block.
// ---------------------------------------------------------------------------
package rpc_pkg;

    // sample and result format
    localparam int SAMPLE_BITS = 16;
    localparam int WLEN_BITS   = 9;
    localparam int QBITS       = 15;

    // wide multiplier: operand width and digit width taken per cycle
    localparam int MUL_W  = 64;
    localparam int DIG_W  = 16;
    localparam int NDIG   = MUL_W / DIG_W;

    // comparison width of the root search: 2*MUL_W plus the Q1.15 headroom
    localparam int ACC_W  = 2 * MUL_W + 2 * QBITS + 2;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic [2*MUL_W-1:0] d;
        logic [ACC_W-1:0]   r;
    } t_srch_req;

endpackage

// ----- hw/rtl/rpc_ram.sv -----
// ---------------------------------------------------------------------------
// rpc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rpc_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rpc_mul.sv -----
// ---------------------------------------------------------------------------
// rpc_mul
// Unsigned MUL_W x MUL_W multiplier, one DIG_W-bit digit of b per cycle.
// ---------------------------------------------------------------------------
module rpc_mul
    import rpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    output logic               o_done,
    output logic [2*MUL_W-1:0] o_prod
);

    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [MUL_W-1:0]         r_a;
    logic [MUL_W-1:0]         r_b;
    logic [MUL_W-1:0]         r_h;
    logic [MUL_W-1:0]         r_l;
    logic [MUL_W+DIG_W-1:0]   s;

    // partial product of one digit plus the running high part
    assign s = (MUL_W+DIG_W)'(r_a) * (MUL_W+DIG_W)'(r_b[DIG_W-1:0])
             + (MUL_W+DIG_W)'(r_h);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NDIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift finished low digits out into r_l
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_h <= '0;
        end else if (r_busy) begin
            r_h <= s[MUL_W+DIG_W-1:DIG_W];
            r_l <= {s[DIG_W-1:0], r_l[MUL_W-1:DIG_W]};
            r_b <= r_b >> DIG_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_h, r_l};

endmodule

// ----- hw/rtl/rpc_qsearch.sv -----
// ---------------------------------------------------------------------------
// rpc_qsearch
// Largest q < 2^QBITS with q*q*d <= r, one result bit per trial step and compare step.
// ---------------------------------------------------------------------------
module rpc_qsearch
    import rpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_srch_req        i_req,
    output logic             o_done,
    output logic [QBITS-1:0] o_q
);

    localparam int K_W = $clog2(QBITS);

    logic             r_busy;
    logic             r_done;
    logic             r_ph;
    logic [K_W-1:0]   r_k;
    logic [QBITS-1:0] r_q;
    logic [ACC_W-1:0] r_r;
    logic [ACC_W-1:0] r_lsq;   // q*q*d so far
    logic [ACC_W-1:0] r_f;     // cross term (q*d) << (k+1)
    logic [ACC_W-1:0] r_dk;    // d << 2k
    logic [ACC_W-1:0] r_t;
    logic [ACC_W-1:0] cand;
    logic             take;

    assign cand = r_lsq + r_t;
    assign take = (cand <= r_r);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
                r_k    <= K_W'(QBITS - 1);
            end else if (r_busy) begin
                r_ph <= !r_ph;
                if (r_ph) begin
                    if (r_k == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
            end
        end
    end

    // datapath: trial bit, then compare and keep
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_r   <= i_req.r;
            r_lsq <= '0;
            r_f   <= '0;
            r_q   <= '0;
            r_dk  <= ACC_W'(i_req.d) << (2 * (QBITS - 1));
        end else if (r_busy) begin
            if (!r_ph) begin
                r_t <= r_f + r_dk;
            end else begin
                if (take) begin
                    r_lsq <= cand;
                    r_f   <= (r_f >> 1) + r_dk;
                    r_q   <= r_q | (QBITS'(1) << r_k);
                end else begin
                    r_f <= r_f >> 1;
                end
                r_dk <= r_dk >> 2;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

// ----- hw/rtl/rolling_pearson_correlation_top.sv -----
// ---------------------------------------------------------------------------
// rolling_pearson_correlation_top
// Pearson correlation over a sliding window of sample pairs.
// ---------------------------------------------------------------------------
// Each accepted word stores a pair in a ring RAM and updates running sums of
// a, b, a*a, b*b and a*b. Once window_len pairs have been taken since the last
// restart, each word yields one result word in signed Q1.15, truncated toward
// zero and saturated at 32767; a window with zero variance gives 0 and sets
// flat_window. A word that gives no result goes through the delta and sum
// states only. A result takes eight wide products through one 16-bit-digit
// multiplier and a 15-bit root search; a flat window ends after the fourth
// product. Writing window_len restarts filling. The ring RAM needs no
// clearing after reset.
module rolling_pearson_correlation_top
    import rpc_pkg::*;
#(
    parameter int MAX_WINDOW = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [WLEN_BITS-1:0]          i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_a,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_b,
    input  logic                          i_new_series,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_corr,
    output logic                          o_flat_window
);

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int SA_W = SAMPLE_BITS + AW;
    localparam int SQ_W = 2 * SAMPLE_BITS + AW;
    localparam int PW   = 2 * SAMPLE_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DELTA = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_MST   = 3'd3;
    localparam logic [2:0] ST_MWT   = 3'd4;
    localparam logic [2:0] ST_SST   = 3'd5;
    localparam logic [2:0] ST_SRCH  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [2:0] PH_NAA = 3'd0;
    localparam logic [2:0] PH_SAA = 3'd1;
    localparam logic [2:0] PH_NBB = 3'd2;
    localparam logic [2:0] PH_SBB = 3'd3;
    localparam logic [2:0] PH_NAB = 3'd4;
    localparam logic [2:0] PH_SAB = 3'd5;
    localparam logic [2:0] PH_DEN = 3'd6;
    localparam logic [2:0] PH_NUM = 3'd7;

    logic [2:0]                    r_state;
    logic [2:0]                    r_ph;
    logic [WLEN_BITS-1:0]          r_wlen;
    logic [AW-1:0]                 r_ws;
    logic [WW-1:0]                 r_fill;
    logic                          r_ev;
    logic signed [SAMPLE_BITS-1:0] r_a;
    logic signed [SAMPLE_BITS-1:0] r_b;
    logic signed [SA_W-1:0]        r_sa, r_sb, r_da, r_db;
    logic signed [SQ_W-1:0]        r_saa, r_sbb, r_sab, r_daa, r_dbb, r_dab;
    logic [MUL_W-1:0]              r_t1, r_va, r_vb, r_num;
    logic                          r_nneg;
    logic [2*MUL_W-1:0]            r_den;
    logic [ACC_W-1:0]              r_rhs;
    logic                          r_flat;
    logic [QBITS-1:0]              r_q;
    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_corr;
    logic                          r_oflat;

    logic [31:0]                   wl32, w32, ws32, old32;
    logic [WW-1:0]                 w;
    logic [AW-1:0]                 old_addr;
    logic [AW-1:0]                 ws_next;
    logic [WW-1:0]                 fill_eff;
    logic                          accept;
    logic [PW-1:0]                 rdata;
    logic signed [SAMPLE_BITS-1:0] oa, ob;
    logic signed [PW-1:0]          pa_new, pb_new, pab_new, pa_old, pb_old, pab_old;
    logic [MUL_W-1:0]              m_n, m_sa, m_sb, m_saa, m_sbb, m_sab;
    logic signed [MUL_W-1:0]       x_sa, x_sb, x_sab;
    logic                          sab_neg, q_neg;
    t_mul_req                      mreq;
    logic                          mdone;
    logic [2*MUL_W-1:0]            mprod;
    logic [MUL_W-1:0]              plo;
    logic [MUL_W-1:0]              vsub;
    t_srch_req                     sreq;
    logic                          sdone;
    logic [QBITS-1:0]              sq;

    // effective window: zero counts as one, clamp at the ring depth
    assign wl32 = 32'(r_wlen);
    assign w32  = (wl32 == 32'd0) ? 32'd1 :
                  (wl32 > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : wl32;
    assign w    = w32[WW-1:0];

    // slot of the pair that leaves the window
    assign ws32     = 32'(r_ws);
    assign old32    = (ws32 >= w32) ? ws32 - w32 : ws32 + 32'(MAX_WINDOW) - w32;
    assign old_addr = old32[AW-1:0];
    assign ws_next  = (r_ws == AW'(MAX_WINDOW - 1)) ? '0 : r_ws + 1'b1;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign fill_eff = i_new_series ? '0 : r_fill;
    assign o_stall  = (r_state != ST_IDLE);

    rpc_ram #(
        .W     (PW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_DELTA),
        .i_waddr (r_ws),
        .i_wdata ({r_b, r_a}),
        .i_raddr (old_addr),
        .o_rdata (rdata)
    );

    // products of the new and the leaving pair
    assign oa      = r_ev ? rdata[SAMPLE_BITS-1:0] : '0;
    assign ob      = r_ev ? rdata[PW-1:SAMPLE_BITS] : '0;
    assign pa_new  = r_a * r_a;
    assign pb_new  = r_b * r_b;
    assign pab_new = r_a * r_b;
    assign pa_old  = oa * oa;
    assign pb_old  = ob * ob;
    assign pab_old = oa * ob;

    // operand magnitudes for the wide products
    assign x_sa  = {{(MUL_W-SA_W){r_sa[SA_W-1]}}, r_sa};
    assign x_sb  = {{(MUL_W-SA_W){r_sb[SA_W-1]}}, r_sb};
    assign x_sab = {{(MUL_W-SQ_W){r_sab[SQ_W-1]}}, r_sab};
    assign m_n   = MUL_W'(w);
    assign m_sa  = x_sa[MUL_W-1] ? -x_sa : x_sa;
    assign m_sb  = x_sb[MUL_W-1] ? -x_sb : x_sb;
    assign m_sab = x_sab[MUL_W-1] ? -x_sab : x_sab;
    assign m_saa = MUL_W'(r_saa);
    assign m_sbb = MUL_W'(r_sbb);
    assign sab_neg = r_sab[SQ_W-1];
    assign q_neg   = (r_sa[SA_W-1] == r_sb[SA_W-1]);

    // select multiplier operands by phase
    always_comb begin
        mreq.start = (r_state == ST_MST);
        case (r_ph)
            PH_NAA: begin mreq.a = m_n;   mreq.b = m_saa; end
            PH_SAA: begin mreq.a = m_sa;  mreq.b = m_sa;  end
            PH_NBB: begin mreq.a = m_n;   mreq.b = m_sbb; end
            PH_SBB: begin mreq.a = m_sb;  mreq.b = m_sb;  end
            PH_NAB: begin mreq.a = m_n;   mreq.b = m_sab; end
            PH_SAB: begin mreq.a = m_sa;  mreq.b = m_sb;  end
            PH_DEN: begin mreq.a = r_va;  mreq.b = r_vb;  end
            PH_NUM: begin mreq.a = r_num; mreq.b = r_num; end
            default: begin mreq.a = '0;   mreq.b = '0;    end
        endcase
    end

    rpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mdone),
        .o_prod  (mprod)
    );

    assign plo  = mprod[MUL_W-1:0];
    assign vsub = (r_t1 >= plo) ? r_t1 - plo : '0;

    assign sreq.start = (r_state == ST_SST);
    assign sreq.d     = r_den;
    assign sreq.r     = r_rhs;

    rpc_qsearch u_srch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sreq),
        .o_done  (sdone),
        .o_q     (sq)
    );

    // sequencer and window control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ph     <= PH_NAA;
            r_wlen   <= WLEN_BITS'(16);
            r_ws     <= '0;
            r_fill   <= '0;
            r_ev     <= 1'b0;
            r_ovalid <= 1'b0;
            r_sa     <= '0;
            r_sb     <= '0;
            r_saa    <= '0;
            r_sbb    <= '0;
            r_sab    <= '0;
        end else begin
            // raise the result word when loaded, drop it once taken
            if (r_state == ST_DONE && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_wlen <= i_cfg_data;
                r_fill <= '0;
                r_sa   <= '0;
                r_sb   <= '0;
                r_saa  <= '0;
                r_sbb  <= '0;
                r_sab  <= '0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_new_series) begin
                            r_sa  <= '0;
                            r_sb  <= '0;
                            r_saa <= '0;
                            r_sbb <= '0;
                            r_sab <= '0;
                        end
                        if (fill_eff >= w) begin
                            r_ev   <= 1'b1;
                            r_fill <= fill_eff;
                        end else begin
                            r_ev   <= 1'b0;
                            r_fill <= fill_eff + 1'b1;
                        end
                        r_state <= ST_DELTA;
                    end
                end
                ST_DELTA: begin
                    r_ws    <= ws_next;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_sa  <= r_sa + r_da;
                    r_sb  <= r_sb + r_db;
                    r_saa <= r_saa + r_daa;
                    r_sbb <= r_sbb + r_dbb;
                    r_sab <= r_sab + r_dab;
                    r_ph  <= PH_NAA;
                    r_state <= (r_fill >= w) ? ST_MST : ST_IDLE;
                end
                ST_MST: begin
                    r_state <= ST_MWT;
                end
                ST_MWT: begin
                    if (mdone) begin
                        r_ph <= r_ph + 1'b1;
                        if (r_ph == PH_SBB && (r_va == '0 || vsub == '0)) begin
                            r_state <= ST_DONE;
                        end else if (r_ph == PH_NUM) begin
                            r_state <= ST_SST;
                        end else begin
                            r_state <= ST_MST;
                        end
                    end
                end
                ST_SST: begin
                    r_state <= ST_SRCH;
                end
                ST_SRCH: begin
                    if (sdone) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_a    <= i_sample_a;
                r_b    <= i_sample_b;
                r_flat <= 1'b0;
            end
            ST_DELTA: begin
                r_da  <= SA_W'(r_a) - SA_W'(oa);
                r_db  <= SA_W'(r_b) - SA_W'(ob);
                r_daa <= SQ_W'(pa_new) - SQ_W'(pa_old);
                r_dbb <= SQ_W'(pb_new) - SQ_W'(pb_old);
                r_dab <= SQ_W'(pab_new) - SQ_W'(pab_old);
            end
            ST_MWT: begin
                if (mdone) begin
                    case (r_ph)
                        PH_NAA: r_t1 <= plo;
                        PH_SAA: r_va <= vsub;
                        PH_NBB: r_t1 <= plo;
                        PH_SBB: begin
                            r_vb   <= vsub;
                            r_flat <= (r_va == '0) || (vsub == '0);
                        end
                        PH_NAB: r_t1 <= plo;
                        PH_SAB: begin
                            if (sab_neg == q_neg) begin
                                r_num  <= r_t1 + plo;
                                r_nneg <= sab_neg;
                            end else if (r_t1 >= plo) begin
                                r_num  <= r_t1 - plo;
                                r_nneg <= sab_neg;
                            end else begin
                                r_num  <= plo - r_t1;
                                r_nneg <= q_neg;
                            end
                        end
                        PH_DEN: r_den <= mprod;
                        PH_NUM: r_rhs <= ACC_W'(mprod) << (2 * QBITS);
                        default: r_t1 <= r_t1;
                    endcase
                end
            end
            ST_SRCH: begin
                if (sdone) begin
                    r_q <= sq;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    r_oflat <= r_flat;
                    if (r_flat) begin
                        r_corr <= '0;
                    end else if (r_nneg) begin
                        r_corr <= -$signed({1'b0, r_q});
                    end else begin
                        r_corr <= $signed({1'b0, r_q});
                    end
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_corr        = r_corr;
    assign o_flat_window = r_oflat;

endmodule
